// ===== hdl/lws_pkg.sv =====
// ----------------------------------------------------------------------------
// lws_pkg
// Shared widths, codes, types and constants of the latency window statistics
// unit.
// ----------------------------------------------------------------------------
package lws_pkg;

  localparam int DelayW  = 32;
  localparam int CountW  = 16;
  localparam int SumW    = 48;
  localparam int OpW     = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  // divider: a magnitude step, then one quotient bit per cycle
  localparam int DivSteps = SumW + 1;
  localparam int DivCntW  = $clog2(DivSteps + 2);

  localparam logic [OpW-1:0] OP_START    = 2'd0;
  localparam logic [OpW-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OpW-1:0] OP_ANOMALY  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_WARNING  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CRITICAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOOPS    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_FIRST    = 2'd3;

  localparam logic [CountW-1:0] MAX_LOOPS    = 16'hffff;
  localparam logic [CountW-1:0] TALLY_MAX    = 16'hffff;
  localparam logic [CountW-1:0] LOOPS_RESET  = 16'd1000;
  localparam logic [CountW-1:0] FIRST_RESET  = 16'd1;
  localparam logic [DelayW-1:0] MIN_INIT     = 32'h7fffffff;
  localparam logic [DelayW-1:0] MAX_INIT     = 32'h80000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_S,
    ST_DIV_S,
    ST_LOAD_C,
    ST_DIV_C,
    ST_PUBLISH
  } lws_state_e;

  typedef struct packed {
    logic ready;
    logic accept;
    logic div_load;
    logic div_sel;
    logic div_step;
    logic keep_start;
    logic publish;
  } lws_cmd_t;

  typedef struct packed {
    logic report;
    logic div_done;
    logic out_free;
  } lws_stat_t;

  typedef struct packed {
    logic signed [DelayW-1:0] start_lo;
    logic signed [DelayW-1:0] start_hi;
    logic signed [DelayW-1:0] start_mean;
    logic signed [DelayW-1:0] compl_lo;
    logic signed [DelayW-1:0] compl_hi;
    logic signed [DelayW-1:0] compl_mean;
    logic [CountW-1:0]        warning_count;
    logic [CountW-1:0]        critical_count;
    logic [CountW-1:0]        anomaly_count;
  } lws_result_t;

endpackage

// ===== hdl/lws_if.sv =====
// ----------------------------------------------------------------------------
// lws_if
// Valid/ready channels of the latency window statistics unit: sample words
// in, report words out.
// ----------------------------------------------------------------------------
interface lws_in_if;
  import lws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           operation;
  logic signed [DelayW-1:0] delay;

  modport source (output valid, output operation, output delay, input ready);
  modport sink   (input valid, input operation, input delay, output ready);
endinterface

interface lws_out_if;
  import lws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DelayW-1:0] start_lo;
  logic signed [DelayW-1:0] start_hi;
  logic signed [DelayW-1:0] start_mean;
  logic signed [DelayW-1:0] compl_lo;
  logic signed [DelayW-1:0] compl_hi;
  logic signed [DelayW-1:0] compl_mean;
  logic [CountW-1:0]        warning_count;
  logic [CountW-1:0]        critical_count;
  logic [CountW-1:0]        anomaly_count;

  modport source (
    output valid, output start_lo, output start_hi, output start_mean,
    output compl_lo, output compl_hi, output compl_mean,
    output warning_count, output critical_count, output anomaly_count,
    input ready
  );
  modport sink (
    input valid, input start_lo, input start_hi, input start_mean,
    input compl_lo, input compl_hi, input compl_mean,
    input warning_count, input critical_count, input anomaly_count,
    output ready
  );
endinterface

// ===== hdl/lws_ctrl.sv =====
// ----------------------------------------------------------------------------
// lws_ctrl
// Sequencer: takes sample words, and at a window end runs the two averaging
// divisions and hands the report to the output register.
// ----------------------------------------------------------------------------
module lws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  lws_pkg::lws_stat_t stat_i,
  output lws_pkg::lws_cmd_t  cmd_o
);
  import lws_pkg::*;

  lws_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.report) state_d = ST_LOAD_S;
      end
      ST_LOAD_S: state_d = ST_DIV_S;
      ST_DIV_S: begin
        if (stat_i.div_done) state_d = ST_LOAD_C;
      end
      ST_LOAD_C: state_d = ST_DIV_C;
      ST_DIV_C: begin
        if (stat_i.div_done) state_d = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.ready  = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_LOAD_S: begin
        cmd_o.div_load = 1'b1;
      end
      ST_DIV_S: begin
        cmd_o.div_step = !stat_i.div_done;
      end
      ST_LOAD_C: begin
        cmd_o.div_load   = 1'b1;
        cmd_o.div_sel    = 1'b1;
        cmd_o.keep_start = 1'b1;
      end
      ST_DIV_C: begin
        cmd_o.div_step = !stat_i.div_done;
      end
      ST_PUBLISH: begin
        cmd_o.publish = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/lws_dp.sv =====
// ----------------------------------------------------------------------------
// lws_dp
// Datapath: settings, window statistics, report snapshot, serial restoring
// divider for the rounded averages, and the output register.
// ----------------------------------------------------------------------------
module lws_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lws_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lws_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [lws_pkg::OpW-1:0]     in_op_i,
  input  logic signed [lws_pkg::DelayW-1:0] in_delay_i,
  input  logic                       out_ready_i,
  input  lws_pkg::lws_cmd_t           cmd_i,
  output lws_pkg::lws_stat_t          stat_o,
  output logic                       out_valid_o,
  output lws_pkg::lws_result_t        out_res_o
);
  import lws_pkg::*;

  function automatic logic [CountW-1:0] clamp_len(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = v;
    if (v == '0) r = CountW'(1);
    else if (v > MAX_LOOPS) r = MAX_LOOPS;
    return r;
  endfunction

  function automatic logic [CountW-1:0] tally_inc(input logic [CountW-1:0] t);
    return (t != TALLY_MAX) ? t + CountW'(1) : t;
  endfunction

  function automatic logic [DelayW-1:0] sat32(input logic [SumW:0] q, input logic neg);
    logic [DelayW-1:0] r;
    if (neg) begin
      r = (q > {{(SumW+1-DelayW){1'b0}}, MAX_INIT}) ? MAX_INIT : (~q[DelayW-1:0] + 1'b1);
    end else begin
      r = (q > {{(SumW+1-DelayW){1'b0}}, MIN_INIT}) ? MIN_INIT : q[DelayW-1:0];
    end
    return r;
  endfunction

  // settings
  logic signed [DelayW-1:0] warn_lim_q, crit_lim_q;
  logic [CountW-1:0]        loops_q;

  // window state
  logic [CountW-1:0]        window_left_q;
  logic                     warmup_q;
  logic [SumW-1:0]          sum_s_q, sum_c_q, sum_s_d, sum_c_d;
  logic signed [DelayW-1:0] lo_s_q, hi_s_q, lo_c_q, hi_c_q;
  logic signed [DelayW-1:0] lo_s_d, hi_s_d, lo_c_d, hi_c_d;
  logic [CountW-1:0]        warn_q, crit_q, user_q, warn_d, crit_d, user_d;

  // snapshot and divider
  lws_result_t       hold_q;
  logic [SumW-1:0]   hs_q, hc_q;
  logic [CountW-1:0] n_q;
  logic [SumW:0]     dvd_q;
  logic [CountW-1:0] rem_q;
  logic              neg_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DelayW-1:0] avg_s_q;

  logic              out_valid_q;
  lws_result_t       out_res_q;
  lws_result_t       pub_res;

  logic              is_s, is_c, is_a, crit_hit, warn_hit, win_end;
  logic [SumW-1:0]   d_ext;
  logic [CountW-1:0] n_new;
  logic [SumW:0]     div_x, div_mag;
  logic [CountW:0]   trial;
  logic              trial_ge;

  assign is_s     = cmd_i.accept && (in_op_i == OP_START);
  assign is_c     = cmd_i.accept && (in_op_i == OP_COMPLETE);
  assign is_a     = cmd_i.accept && (in_op_i == OP_ANOMALY);
  assign d_ext    = {{(SumW-DelayW){in_delay_i[DelayW-1]}}, in_delay_i};
  assign crit_hit = in_delay_i > crit_lim_q;
  assign warn_hit = !crit_hit && (in_delay_i > warn_lim_q);
  assign win_end  = is_c && (window_left_q == CountW'(1));
  assign n_new    = clamp_len(loops_q);

  assign stat_o.report   = (in_op_i == OP_COMPLETE) && (window_left_q == CountW'(1))
                           && !warmup_q;
  assign stat_o.div_done = (cnt_q == DivCntW'(DivSteps + 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    lo_s_d  = (is_s && (in_delay_i < lo_s_q)) ? in_delay_i : lo_s_q;
    hi_s_d  = (is_s && (in_delay_i > hi_s_q)) ? in_delay_i : hi_s_q;
    lo_c_d  = (is_c && (in_delay_i < lo_c_q)) ? in_delay_i : lo_c_q;
    hi_c_d  = (is_c && (in_delay_i > hi_c_q)) ? in_delay_i : hi_c_q;
    sum_s_d = is_s ? sum_s_q + d_ext : sum_s_q;
    sum_c_d = is_c ? sum_c_q + d_ext : sum_c_q;
    crit_d  = (is_c && crit_hit) ? tally_inc(crit_q) : crit_q;
    warn_d  = (is_c && warn_hit) ? tally_inc(warn_q) : warn_q;
    user_d  = is_a ? tally_inc(user_q) : user_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_lim_q    <= '0;
      crit_lim_q    <= '0;
      loops_q       <= LOOPS_RESET;
      window_left_q <= clamp_len(FIRST_RESET);
      warmup_q      <= 1'b1;
      sum_s_q       <= '0;
      sum_c_q       <= '0;
      lo_s_q        <= MIN_INIT;
      hi_s_q        <= MAX_INIT;
      lo_c_q        <= MIN_INIT;
      hi_c_q        <= MAX_INIT;
      warn_q        <= '0;
      crit_q        <= '0;
      user_q        <= '0;
    end else begin
      if (win_end) begin
        window_left_q <= n_new;
        warmup_q      <= 1'b0;
        sum_s_q       <= '0;
        sum_c_q       <= '0;
        lo_s_q        <= MIN_INIT;
        hi_s_q        <= MAX_INIT;
        lo_c_q        <= MIN_INIT;
        hi_c_q        <= MAX_INIT;
        warn_q        <= '0;
        crit_q        <= '0;
        user_q        <= '0;
      end else begin
        if (is_c) window_left_q <= window_left_q - CountW'(1);
        sum_s_q <= sum_s_d;
        sum_c_q <= sum_c_d;
        lo_s_q  <= lo_s_d;
        hi_s_q  <= hi_s_d;
        lo_c_q  <= lo_c_d;
        hi_c_q  <= hi_c_d;
        warn_q  <= warn_d;
        crit_q  <= crit_d;
        user_q  <= user_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WARNING:  warn_lim_q <= cfg_data_i[DelayW-1:0];
          REG_CRITICAL: crit_lim_q <= cfg_data_i[DelayW-1:0];
          REG_LOOPS:    loops_q    <= cfg_data_i[CountW-1:0];
          REG_FIRST: begin
            if (warmup_q) window_left_q <= clamp_len(cfg_data_i[CountW-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  // divider: dividend is sum + n/2, worked on as sign and magnitude
  assign div_x    = {cmd_i.div_sel ? hc_q[SumW-1] : hs_q[SumW-1],
                     cmd_i.div_sel ? hc_q : hs_q}
                    + {{(SumW+2-CountW){1'b0}}, n_q[CountW-1:1]};
  assign div_mag  = dvd_q[SumW] ? (~dvd_q + 1'b1) : dvd_q;
  assign trial    = {rem_q, dvd_q[SumW]};
  assign trial_ge = trial >= {1'b0, n_q};

  always_comb begin
    pub_res            = hold_q;
    pub_res.start_mean = avg_s_q;
    pub_res.compl_mean = sat32(dvd_q, neg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.div_load) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + DivCntW'(1);
      if (cmd_i.publish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_end) begin
      hold_q.start_lo       <= lo_s_d;
      hold_q.start_hi       <= hi_s_d;
      hold_q.start_mean     <= '0;
      hold_q.compl_lo       <= lo_c_d;
      hold_q.compl_hi       <= hi_c_d;
      hold_q.compl_mean     <= '0;
      hold_q.warning_count  <= warn_d;
      hold_q.critical_count <= crit_d;
      hold_q.anomaly_count  <= user_d;
      hs_q                  <= sum_s_d;
      hc_q                  <= sum_c_d;
      n_q                   <= n_new;
    end
    if (cmd_i.div_load) begin
      dvd_q <= div_x;
    end else if (cmd_i.div_step) begin
      if (cnt_q == '0) begin
        neg_q <= dvd_q[SumW];
        dvd_q <= div_mag;
        rem_q <= '0;
      end else begin
        rem_q <= trial_ge ? CountW'(trial - {1'b0, n_q}) : trial[CountW-1:0];
        dvd_q <= {dvd_q[SumW-1:0], trial_ge};
      end
    end
    if (cmd_i.keep_start) avg_s_q <= sat32(dvd_q, neg_q);
    if (cmd_i.publish) out_res_q <= pub_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== hdl/latency_window_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// latency_window_statistics_unit
// Latency monitor: min/max/average of start and completion delays, limit
// tallies and anomaly count, reported once per window of completions after warm-up.
// ----------------------------------------------------------------------------
// Start, anomaly and non-final completion words: taken back to back, input held ready.
// Window-closing completion: two 49-bit serial divisions (each a load, a magnitude
//   step, then the quotient bits) hold the input off.
// Input reopens as the report enters the output register; a second report
//   waits there until the first is taken.
// Reset: asynchronous, active low; statistics cleared, settings to defaults.
module latency_window_statistics_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lws_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lws_pkg::CfgW-1:0]    cfg_data_i,
  lws_in_if.sink                      in_word_i,
  lws_out_if.source                   out_word_o
);
  import lws_pkg::*;

  lws_cmd_t    cmd;
  lws_stat_t   stat;
  logic        out_valid;
  lws_result_t out_res;

  lws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_word_i.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (in_word_i.operation),
    .in_delay_i  (in_word_i.delay),
    .out_ready_i (out_word_o.ready),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_res_o   (out_res)
  );

  assign in_word_i.ready           = cmd.ready;
  assign out_word_o.valid          = out_valid;
  assign out_word_o.start_lo       = out_res.start_lo;
  assign out_word_o.start_hi       = out_res.start_hi;
  assign out_word_o.start_mean     = out_res.start_mean;
  assign out_word_o.compl_lo       = out_res.compl_lo;
  assign out_word_o.compl_hi       = out_res.compl_hi;
  assign out_word_o.compl_mean     = out_res.compl_mean;
  assign out_word_o.warning_count  = out_res.warning_count;
  assign out_word_o.critical_count = out_res.critical_count;
  assign out_word_o.anomaly_count  = out_res.anomaly_count;

endmodule

// ===== hdl/lws_checker.sv =====
// ----------------------------------------------------------------------------
// lws_checker
// Port-level checks of the latency window statistics unit, bound to the top.
// ----------------------------------------------------------------------------
module lws_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic [lws_pkg::OpW-1:0]           in_op_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [lws_pkg::DelayW-1:0] min_c_i,
  input logic signed [lws_pkg::DelayW-1:0] max_c_i,
  input logic signed [lws_pkg::DelayW-1:0] avg_c_i
);
  import lws_pkg::*;

  // a pending report word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(avg_c_i))
    else $error("report word dropped or changed while stalled");

  // only a completion can close a window, so other words never stall input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i != OP_COMPLETE) |=> in_ready_i)
    else $error("input stalled after a non-completion word");

  // a fresh report only appears while the input side is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("report appeared without a closing window");

  // every reported window holds at least one completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (min_c_i <= max_c_i))
    else $error("completion minimum above maximum");

endmodule

bind latency_window_statistics_unit lws_checker u_lws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_word_i.valid),
  .in_ready_i  (in_word_i.ready),
  .in_op_i     (in_word_i.operation),
  .out_valid_i (out_word_o.valid),
  .out_ready_i (out_word_o.ready),
  .min_c_i     (out_word_o.compl_lo),
  .max_c_i     (out_word_o.compl_hi),
  .avg_c_i     (out_word_o.compl_mean)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the latency window statistics unit. Start, completion
// and anomaly words are driven over the valid/ready input channel with random
// gaps. A tracker predicts each window report and checks it field by field.
// Runs a directed warm-up and edge-case part, then random phases under varied
// limits and window lengths, and ends with a window reported over 65535.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lws_pkg::*;

  localparam logic [OpW-1:0]           OP_UNUSED    = 2'd3;
  localparam logic signed [DelayW-1:0] DELAY_TOP    = 32'sh7fff_ffff;
  localparam logic signed [DelayW-1:0] DELAY_BOTTOM = 32'sh8000_0000;

  class latency_window_tracker;
    logic signed [DelayW-1:0] warn_lim;
    logic signed [DelayW-1:0] crit_lim;
    logic [CountW-1:0]        loops_reg;
    logic [CountW-1:0]        first_reg;

    logic [CountW-1:0]        window_left;
    logic                     in_warmup;
    logic [SumW-1:0]          sum_start;
    logic [SumW-1:0]          sum_complete;
    logic signed [DelayW-1:0] low_start;
    logic signed [DelayW-1:0] high_start;
    logic signed [DelayW-1:0] low_complete;
    logic signed [DelayW-1:0] high_complete;
    logic [CountW-1:0]        warn_tally;
    logic [CountW-1:0]        crit_tally;
    logic [CountW-1:0]        user_tally;

    lws_result_t reports_due[$];
    int errors;
    int words_seen;
    int reports_seen;
    int cfg_writes;

    function new();
      warn_lim    = '0;
      crit_lim    = '0;
      loops_reg   = LOOPS_RESET;
      first_reg   = FIRST_RESET;
      window_left = length_of(first_reg);
      in_warmup   = 1'b1;
      clear_window();
    endfunction

    function logic [CountW-1:0] length_of(logic [CountW-1:0] v);
      return (v == '0) ? 16'd1 : v;
    endfunction

    function logic [CountW-1:0] bump(logic [CountW-1:0] t);
      return (t == TALLY_MAX) ? t : t + 16'd1;
    endfunction

    function void clear_window();
      sum_start     = '0;
      sum_complete  = '0;
      low_start     = MIN_INIT;
      high_start    = MAX_INIT;
      low_complete  = MIN_INIT;
      high_complete = MAX_INIT;
      warn_tally    = '0;
      crit_tally    = '0;
      user_tally    = '0;
    endfunction

    // rounded mean over the window length, 48-bit sum taken as signed
    function logic signed [DelayW-1:0] mean_of(logic [SumW-1:0] sum, logic [CountW-1:0] n);
      longint s;
      longint len;
      longint q;
      s   = longint'($signed(sum));
      len = longint'(n);
      q   = (s + len / 2) / len;
      if (q > 64'sh7fff_ffff) return DELAY_TOP;
      if (q < -64'sh8000_0000) return DELAY_BOTTOM;
      return q[DelayW-1:0];
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      cfg_writes++;
      case (idx)
        REG_WARNING:  warn_lim = data;
        REG_CRITICAL: crit_lim = data;
        REG_LOOPS:    loops_reg = data[CountW-1:0];
        REG_FIRST: begin
          first_reg = data[CountW-1:0];
          if (in_warmup) window_left = length_of(first_reg);
        end
        default: ;
      endcase
    endfunction

    function void note_word(logic [OpW-1:0] op, logic signed [DelayW-1:0] d);
      lws_result_t rep;
      logic [CountW-1:0] n;
      words_seen++;
      case (op)
        OP_START: begin
          if (d < low_start) low_start = d;
          if (d > high_start) high_start = d;
          sum_start = sum_start + {{(SumW-DelayW){d[DelayW-1]}}, d};
        end
        OP_ANOMALY: user_tally = bump(user_tally);
        OP_COMPLETE: begin
          if (d < low_complete) low_complete = d;
          if (d > high_complete) high_complete = d;
          sum_complete = sum_complete + {{(SumW-DelayW){d[DelayW-1]}}, d};
          if (d > crit_lim) crit_tally = bump(crit_tally);
          else if (d > warn_lim) warn_tally = bump(warn_tally);
          window_left = window_left - 16'd1;
          if (window_left == '0) begin
            n = length_of(loops_reg);
            if (!in_warmup) begin
              rep.start_lo       = low_start;
              rep.start_hi       = high_start;
              rep.start_mean     = mean_of(sum_start, n);
              rep.compl_lo       = low_complete;
              rep.compl_hi       = high_complete;
              rep.compl_mean     = mean_of(sum_complete, n);
              rep.warning_count  = warn_tally;
              rep.critical_count = crit_tally;
              rep.anomaly_count  = user_tally;
              reports_due.push_back(rep);
            end
            in_warmup   = 1'b0;
            window_left = n;
            clear_window();
          end
        end
        default: ;
      endcase
    endfunction

    function void match(string name, logic signed [63:0] want, logic signed [63:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_report(lws_result_t got);
      lws_result_t want;
      reports_seen++;
      if (reports_due.size() == 0) begin
        $error("report word with no window closed (start_lo %0d, anomaly_count %0d)",
               got.start_lo, got.anomaly_count);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      match("start_lo",       want.start_lo,       got.start_lo);
      match("start_hi",       want.start_hi,       got.start_hi);
      match("start_mean",     want.start_mean,     got.start_mean);
      match("compl_lo",       want.compl_lo,       got.compl_lo);
      match("compl_hi",       want.compl_hi,       got.compl_hi);
      match("compl_mean",     want.compl_mean,     got.compl_mean);
      match("warning_count",  want.warning_count,  got.warning_count);
      match("critical_count", want.critical_count, got.critical_count);
      match("anomaly_count",  want.anomaly_count,  got.anomaly_count);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;
  logic                quiet;

  lws_in_if  in_word ();
  lws_out_if out_word ();

  latency_window_tracker board = new();

  latency_window_statistics_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_word_i   (in_word.sink),
    .out_word_o  (out_word.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #12ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(15, 4);
    return $urandom_range(120, 30);
  endfunction

  // delays clustered round the limits, the extremes and zero
  function automatic logic signed [DelayW-1:0] pick_delay();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4:    return board.warn_lim + (int'($urandom_range(4)) - 2);
      5, 6:    return board.crit_lim + (int'($urandom_range(4)) - 2);
      7:       return $urandom_range(1) ? DELAY_TOP : DELAY_BOTTOM;
      default: return int'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  task automatic send_word(input logic [OpW-1:0] op, input logic signed [DelayW-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid     <= 1'b1;
    in_word.operation <= op;
    in_word.delay     <= d;
    do @(posedge clk); while (!in_word.ready);
    board.note_word(op, d);
  endtask

  task automatic random_words(input int count);
    int r;
    logic [OpW-1:0] op;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 38) op = OP_START;
      else if (r < 78) op = OP_COMPLETE;
      else if (r < 95) op = OP_ANOMALY;
      else op = OP_UNUSED;
      send_word(op, (op == OP_ANOMALY || op == OP_UNUSED) ? $urandom : pick_delay());
    end
  endtask

  task automatic drain_reports(input int settle);
    in_word.valid <= 1'b0;
    do @(posedge clk); while (board.reports_due.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.note_config(idx, data);
  endtask

  task automatic set_phase(input logic [CfgW-1:0] warn, input logic [CfgW-1:0] crit,
                           input logic [CfgW-1:0] loops, input logic [CfgW-1:0] first);
    write_reg(REG_WARNING, warn);
    write_reg(REG_CRITICAL, crit);
    write_reg(REG_LOOPS, loops);
    write_reg(REG_FIRST, first);
    cfg_we <= 1'b0;
  endtask

  initial begin : report_sink
    int stall;
    lws_result_t got;
    stall = 0;
    out_word.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_word.valid && out_word.ready) begin
        got.start_lo       = out_word.start_lo;
        got.start_hi       = out_word.start_hi;
        got.start_mean     = out_word.start_mean;
        got.compl_lo       = out_word.compl_lo;
        got.compl_hi       = out_word.compl_hi;
        got.compl_mean     = out_word.compl_mean;
        got.warning_count  = out_word.warning_count;
        got.critical_count = out_word.critical_count;
        got.anomaly_count  = out_word.anomaly_count;
        board.check_report(got);
      end
      if (stall > 0) begin
        out_word.ready <= 1'b0;
        stall--;
      end else begin
        out_word.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    quiet             = 1'b0;
    rst_n             = 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_word.valid     <= 1'b0;
    in_word.operation <= '0;
    in_word.delay     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warm-up length reloaded on each write, zero taken as one
    write_reg(REG_FIRST, 32'h0000_ffff);
    write_reg(REG_FIRST, 32'h0000_0000);
    set_phase(32'd100, 32'd1000, 32'h0001_0002, 32'hffff_0003);

    // warm-up window, report discarded
    send_word(OP_START, 32'sd5);
    send_word(OP_ANOMALY, $urandom);
    send_word(OP_UNUSED, $urandom);
    send_word(OP_COMPLETE, 32'sd2000);
    send_word(OP_COMPLETE, 32'sd500);
    send_word(OP_COMPLETE, -32'sd7);
    // extreme delays
    send_word(OP_START, DELAY_BOTTOM);
    send_word(OP_START, DELAY_TOP);
    send_word(OP_ANOMALY, $urandom);
    send_word(OP_UNUSED, $urandom);
    send_word(OP_COMPLETE, DELAY_TOP);
    send_word(OP_COMPLETE, DELAY_BOTTOM);
    // no start samples; delays equal to the limits
    send_word(OP_COMPLETE, 32'sd1000);
    send_word(OP_COMPLETE, 32'sd100);
    // averages beyond the 32-bit range
    repeat (3) send_word(OP_START, DELAY_TOP);
    send_word(OP_COMPLETE, 32'sd1001);
    send_word(OP_COMPLETE, 32'sd101);
    repeat (3) send_word(OP_START, DELAY_BOTTOM);
    send_word(OP_COMPLETE, -32'sd5);
    send_word(OP_COMPLETE, 32'sd0);

    drain_reports(130);
    set_phase(-32'sd50, 32'sd50, 32'd3, $urandom);
    random_words(170);

    drain_reports(130);
    set_phase(DELAY_BOTTOM, DELAY_TOP, 32'habcd_0000, $urandom);
    quiet = 1'b1;
    random_words(170);
    quiet = 1'b0;

    drain_reports(130);
    set_phase(DELAY_TOP, DELAY_BOTTOM, 32'd2, $urandom);
    random_words(170);

    drain_reports(130);
    set_phase($urandom, $urandom, $urandom_range(6, 1), $urandom);
    random_words(85);
    drain_reports(0);
    random_words(85);

    drain_reports(130);
    set_phase($urandom, $urandom, {16'($urandom), 16'($urandom_range(10, 1))}, $urandom);
    random_words(120);

    // longest window length: the open window reports with n = 65535
    drain_reports(130);
    set_phase(32'd0, 32'd1000, 32'hffff_ffff, $urandom);
    while (board.window_left != MAX_LOOPS) random_words(1);

    drain_reports(150);
    if (board.reports_due.size() != 0) begin
      $error("%0d reports never arrived", board.reports_due.size());
      board.errors++;
    end
    $display("Summary: %0d sample words, %0d window reports, %0d register writes",
             board.words_seen, board.reports_seen, board.cfg_writes);
    $display("Covered warm-up reloads, limit edges, clipped means, lengths 1 to 65535");
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== latency_window_statistics_unit.f =====
hdl/lws_pkg.sv
hdl/lws_if.sv
hdl/lws_ctrl.sv
hdl/lws_dp.sv
hdl/latency_window_statistics_unit.sv
hdl/lws_checker.sv
tb/sv/tb_top.sv
